FILE: rtl/dasd_pkg.sv
package dasd_pkg;

  localparam int unsigned YEAR_MAX      = 4095;
  localparam int unsigned DAYS_YEAR     = 365;
  localparam int unsigned DAYS_CYCLE    = 1461;
  localparam int unsigned RECIP_SHIFT   = 32;

  // floor(2^32 / 1461): the quotient estimate is exact or one low
  localparam logic [21:0] RECIP = 22'((64'd1 << RECIP_SHIFT) / 64'(DAYS_CYCLE));

  // day number of 31 December of the last year
  localparam logic [20:0] LAST_DAYNUM =
    21'((YEAR_MAX - 1) * DAYS_YEAR + (YEAR_MAX - 1) / 4 + 334 + 31 - 1);

  // micro-operations
  localparam logic [3:0] OP_IDLE = 4'd0;
  localparam logic [3:0] OP_MULY = 4'd1;
  localparam logic [3:0] OP_DNUM = 4'd2;
  localparam logic [3:0] OP_OFFS = 4'd3;
  localparam logic [3:0] OP_MULR = 4'd4;
  localparam logic [3:0] OP_CYC  = 4'd5;
  localparam logic [3:0] OP_MULC = 4'd6;
  localparam logic [3:0] OP_REM  = 4'd7;
  localparam logic [3:0] OP_YEAR = 4'd8;
  localparam logic [3:0] OP_MDAY = 4'd9;
  localparam logic [3:0] OP_DONE = 4'd10;

  typedef struct packed {
    logic       active;
    logic [3:0] op;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] op;
    logic       jmp_err;
    logic [3:0] target;
  } ucode_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd1: c = 9'd0;
      4'd2: c = 9'd31;
      4'd3: c = 9'd59;
      4'd4: c = 9'd90;
      4'd5: c = 9'd120;
      4'd6: c = 9'd151;
      4'd7: c = 9'd181;
      4'd8: c = 9'd212;
      4'd9: c = 9'd243;
      4'd10: c = 9'd273;
      4'd11: c = 9'd304;
      4'd12: c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m > 4'd2) c = c + 9'd1;
    return c;
  endfunction

endpackage

FILE: rtl/dasd_seq.sv
module dasd_seq
  import dasd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  err,
  input  logic  retire,
  output ctrl_t ctrl
);

  logic [3:0] step;
  logic       active;
  ucode_t     word;

  // microprogram
  always_comb begin
    case (step)
      4'd0: word = '{op: OP_MULY, jmp_err: 1'b0, target: 4'd0};
      4'd1: word = '{op: OP_DNUM, jmp_err: 1'b1, target: 4'd9};
      4'd2: word = '{op: OP_OFFS, jmp_err: 1'b0, target: 4'd0};
      4'd3: word = '{op: OP_MULR, jmp_err: 1'b1, target: 4'd9};
      4'd4: word = '{op: OP_CYC,  jmp_err: 1'b0, target: 4'd0};
      4'd5: word = '{op: OP_MULC, jmp_err: 1'b0, target: 4'd0};
      4'd6: word = '{op: OP_REM,  jmp_err: 1'b0, target: 4'd0};
      4'd7: word = '{op: OP_YEAR, jmp_err: 1'b0, target: 4'd0};
      4'd8: word = '{op: OP_MDAY, jmp_err: 1'b0, target: 4'd0};
      default: word = '{op: OP_DONE, jmp_err: 1'b0, target: 4'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 4'd0;
    end else if (start) begin
      active <= 1'b1;
      step   <= 4'd0;
    end else if (active) begin
      if (word.op == OP_DONE) begin
        if (retire) active <= 1'b0;
      end else if (word.jmp_err && err) begin
        step <= word.target;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  assign ctrl.active = active;
  assign ctrl.op     = active ? word.op : OP_IDLE;

endmodule

FILE: rtl/dasd_dp.sv
module dasd_dp
  import dasd_pkg::*;
(
  input  logic        clk,
  input  logic        start,
  input  ctrl_t       ctrl,
  input  logic        kind,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [11:0] year,
  input  logic [15:0] offset,
  output logic        err,
  output logic [4:0]  res_day,
  output logic [3:0]  res_month,
  output logic [11:0] res_year
);

  logic        kind_r;
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [11:0] year_r;
  logic [15:0] offs_r;

  logic [42:0] prod;
  logic [20:0] n;
  logic [9:0]  cyc;
  logic [10:0] rem;
  logic [11:0] yr;
  logic [4:0]  rday;
  logic [3:0]  rmonth;

  logic [11:0] ym1;
  logic        in_leap;
  logic        in_ok;
  logic [21:0] sum;
  logic [11:0] rem_raw;
  logic [1:0]  yo;
  logic [10:0] yo_days;
  logic        leap;
  logic [3:0]  mon;
  logic [8:0]  mcum;

  assign ym1     = year_r - 12'd1;
  assign in_leap = (year_r[1:0] == 2'b00);
  assign in_ok   = (year_r != 12'd0) && (month_r >= 4'd1) && (month_r <= 4'd12) &&
                   (day_r != 5'd0) && (day_r <= month_len(month_r, in_leap));
  assign sum     = {1'b0, n} + {6'd0, offs_r};
  assign rem_raw = 12'(n - prod[20:0]);

  always_comb begin
    if (rem >= 11'd1095) begin
      yo = 2'd3; yo_days = 11'd1095;
    end else if (rem >= 11'd730) begin
      yo = 2'd2; yo_days = 11'd730;
    end else if (rem >= 11'd365) begin
      yo = 2'd1; yo_days = 11'd365;
    end else begin
      yo = 2'd0; yo_days = 11'd0;
    end
  end

  // month search: independent compares against the month start table
  assign leap = (yr[1:0] == 2'b00);
  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if ({2'b00, rem[8:0]} >= {2'b00, cum_days(4'(k), leap)}) mon = 4'(k);
    end
  end
  assign mcum = cum_days(mon, leap);

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r  <= kind;
      day_r   <= day;
      month_r <= month;
      year_r  <= year;
      offs_r  <= offset;
    end
    case (ctrl.op)
      OP_MULY: begin
        prod <= {22'd0, ym1 * 21'(DAYS_YEAR)};
        err  <= !in_ok;
      end
      OP_DNUM: begin
        n <= prod[20:0] + {11'd0, ym1[11:2]} + {12'd0, cum_days(month_r, in_leap)} +
             {16'd0, day_r} - 21'd1;
      end
      OP_OFFS: begin
        if (kind_r) begin
          n   <= n - {5'd0, offs_r};
          err <= err | (n < {5'd0, offs_r});
        end else begin
          n   <= sum[20:0];
          err <= err | (sum > {1'b0, LAST_DAYNUM});
        end
      end
      OP_MULR: prod <= n * RECIP;
      OP_CYC:  cyc  <= prod[RECIP_SHIFT +: 10];
      OP_MULC: prod <= {22'd0, 21'(cyc) * 21'(DAYS_CYCLE)};
      OP_REM: begin
        // estimate can be one low: single correction
        if (rem_raw >= 12'(DAYS_CYCLE)) begin
          cyc <= cyc + 10'd1;
          rem <= 11'(rem_raw - 12'(DAYS_CYCLE));
        end else begin
          rem <= rem_raw[10:0];
        end
      end
      OP_YEAR: begin
        rem <= rem - yo_days;
        yr  <= {cyc, yo} + 12'd1;
      end
      OP_MDAY: begin
        rmonth <= mon;
        rday   <= 5'(rem[8:0] - mcum + 9'd1);
      end
      default: ;
    endcase
  end

  assign res_day   = err ? day_r   : rday;
  assign res_month = err ? month_r : rmonth;
  assign res_year  = err ? year_r  : yr;

endmodule

FILE: rtl/date_add_subtract_days.sv
// date plus or minus a day count
//
// input transaction: kind, day, month, year, offset, taken when in_valid is
// high and in_stall low. kind 0 adds offset days, kind 1 subtracts them.
// output transaction: out_day, out_month, out_year, error, taken when
// out_valid is high and out_stall low. error repeats the input date.
//
// one item at a time, run by a ten-step microprogram over one datapath
// in which three multiplications share the product register. a new item
// is taken only after the last one has passed its final step. an invalid
// input date jumps from the day-number step to the final step, a result
// out of range from the step after the offset step.
// the result sits in an output register, so a stalled receiver holds only
// the output: the next item is taken and computed, then waits at its last
// step until the output register frees.
// reset empties the output register and idles the sequencer.
module date_add_subtract_days
  import dasd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [11:0] year,
  input  logic [15:0] offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic        error
);

  ctrl_t       ctrl;
  logic        start;
  logic        retire;
  logic        err;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [11:0] res_year;

  // no input transaction while reset is held
  assign in_stall = rst || ctrl.active;
  assign start    = in_valid && !in_stall;
  assign retire   = ctrl.active && (ctrl.op == OP_DONE) && (!out_valid || !out_stall);

  dasd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .err    (err),
    .retire (retire),
    .ctrl   (ctrl)
  );

  dasd_dp u_dp (
    .clk       (clk),
    .start     (start),
    .ctrl      (ctrl),
    .kind      (kind),
    .day       (day),
    .month     (month),
    .year      (year),
    .offset    (offset),
    .err       (err),
    .res_day   (res_day),
    .res_month (res_month),
    .res_year  (res_year)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_day   <= res_day;
      out_month <= res_month;
      out_year  <= res_year;
      error     <= err;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer not busy after input transaction");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == OP_DONE))
    else $error("output loaded outside the final step");

  a_good_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error) |-> (out_day != 5'd0 && out_month >= 4'd1 &&
                               out_month <= 4'd12 && out_year != 12'd0))
    else $error("result date out of range without error");

endmodule

FILE: tb/sv/date_add_subtract_days_tb.sv
module date_add_subtract_days_tb;

  typedef struct packed {
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    logic        err;
  } date_result_t;

  typedef struct packed {
    logic         kind;
    logic [4:0]   d;
    logic [3:0]   m;
    logic [11:0]  y;
    logic [15:0]  offs;
    logic         typed;
    date_result_t want;
  } date_stim_t;

  localparam date_result_t NO_WANT = '0;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM = 1400;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  wire         in_stall;
  logic        kind;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  logic [15:0] offset;
  wire         out_valid;
  logic        out_stall;
  wire  [4:0]  out_day;
  wire  [3:0]  out_month;
  wire  [11:0] out_year;
  wire         error;

  date_result_t pending_dates[$];
  date_stim_t   directed_rows [NUM_DIRECTED];
  int           accepted_count = 0;
  int           mismatch_count = 0;
  bit           hold_done = 1'b0;

  // no random idling on either side in this window
  wire calm_stretch = (accepted_count >= 600) && (accepted_count < 800);

  date_add_subtract_days DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .day       (day),
    .month     (month),
    .year      (year),
    .offset    (offset),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year),
    .error     (error)
  );

  always #5 clk = ~clk;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
    case (m)
      4'd2: return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      default: return 5'd0;
    endcase
  endfunction

  // days since 1 january of year 1
  function automatic int day_count(input logic [4:0] d, input logic [3:0] m,
                                   input logic [11:0] y);
    int n;
    n = (int'(y) - 1) * 365 + (int'(y) - 1) / 4;
    for (int k = 1; k < int'(m); k++) n += int'(month_days(4'(k), y));
    return n + int'(d) - 1;
  endfunction

  function automatic date_result_t shift_date(input logic k, input logic [4:0] d,
                                              input logic [3:0] m, input logic [11:0] y,
                                              input logic [15:0] offs);
    date_result_t r;
    int n;
    int yr0;
    int rem;
    logic [3:0] mo;
    r = '{d: d, m: m, y: y, err: 1'b1};
    if (m < 4'd1 || m > 4'd12 || y == 12'd0 || d == 5'd0 || d > month_days(m, y)) return r;
    n = day_count(d, m, y) + (k ? -int'(offs) : int'(offs));
    if (n < 0 || n > day_count(5'd31, 4'd12, 12'd4095)) return r;
    // zero-based year from the four-year leap cycle
    yr0 = (4 * n + 3) / 1461;
    rem = n - (365 * yr0 + yr0 / 4);
    mo = 4'd1;
    while (rem >= int'(month_days(mo, 12'(yr0 + 1)))) begin
      rem -= int'(month_days(mo, 12'(yr0 + 1)));
      mo = mo + 4'd1;
    end
    r = '{d: 5'(rem + 1), m: mo, y: 12'(yr0 + 1), err: 1'b0};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic offer_date(input date_stim_t s);
    in_valid <= 1'b1;
    kind <= s.kind;
    day <= s.d;
    month <= s.m;
    year <= s.y;
    offset <= s.offs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s.typed) pending_dates.push_back(s.want);
    else pending_dates.push_back(shift_date(s.kind, s.d, s.m, s.y, s.offs));
    accepted_count++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    while (!calm_stretch && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    date_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result transaction", 0, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_day !== want.d) report_mismatch("out_day", out_day, want.d);
        if (out_month !== want.m) report_mismatch("out_month", out_month, want.m);
        if (out_year !== want.y) report_mismatch("out_year", out_year, want.y);
        if (error !== want.err) report_mismatch("error", error, want.err);
      end
    end
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_count >= 300) begin
        // long hold-off so the block fills and pushes back on its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
      end
      out_stall <= !rst && !calm_stretch && ($urandom_range(99) < 13);
    end
  end

  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    date_stim_t s;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    day = 5'd0;
    month = 4'd0;
    year = 12'd0;
    offset = 16'd0;
    directed_rows = '{
      '{1'b0, 5'd15, 4'd6,  12'd2024, 16'd0,     1'b1, '{5'd15, 4'd6,  12'd2024, 1'b0}},
      '{1'b0, 5'd10, 4'd0,  12'd100,  16'd5,     1'b1, '{5'd10, 4'd0,  12'd100,  1'b1}},
      '{1'b1, 5'd10, 4'd13, 12'd100,  16'd5,     1'b1, '{5'd10, 4'd13, 12'd100,  1'b1}},
      '{1'b0, 5'd31, 4'd15, 12'd4095, 16'd65535, 1'b1, '{5'd31, 4'd15, 12'd4095, 1'b1}},
      '{1'b0, 5'd0,  4'd1,  12'd1,    16'd0,     1'b1, '{5'd0,  4'd1,  12'd1,    1'b1}},
      '{1'b1, 5'd1,  4'd1,  12'd0,    16'd0,     1'b1, '{5'd1,  4'd1,  12'd0,    1'b1}},
      '{1'b0, 5'd31, 4'd4,  12'd2023, 16'd1,     1'b1, '{5'd31, 4'd4,  12'd2023, 1'b1}},
      '{1'b0, 5'd29, 4'd2,  12'd2023, 16'd1,     1'b1, '{5'd29, 4'd2,  12'd2023, 1'b1}},
      '{1'b0, 5'd29, 4'd2,  12'd2024, 16'd1,     1'b1, '{5'd1,  4'd3,  12'd2024, 1'b0}},
      '{1'b0, 5'd29, 4'd2,  12'd100,  16'd0,     1'b1, '{5'd29, 4'd2,  12'd100,  1'b0}},
      '{1'b1, 5'd1,  4'd1,  12'd1,    16'd1,     1'b1, '{5'd1,  4'd1,  12'd1,    1'b1}},
      '{1'b1, 5'd1,  4'd1,  12'd1,    16'd0,     1'b1, '{5'd1,  4'd1,  12'd1,    1'b0}},
      '{1'b0, 5'd31, 4'd12, 12'd4095, 16'd1,     1'b1, '{5'd31, 4'd12, 12'd4095, 1'b1}},
      '{1'b0, 5'd31, 4'd12, 12'd4095, 16'd0,     1'b1, '{5'd31, 4'd12, 12'd4095, 1'b0}},
      '{1'b0, 5'd31, 4'd12, 12'd3,    16'd1,     1'b1, '{5'd1,  4'd1,  12'd4,    1'b0}},
      '{1'b1, 5'd1,  4'd3,  12'd5,    16'd1,     1'b1, '{5'd28, 4'd2,  12'd5,    1'b0}},
      '{1'b1, 5'd1,  4'd3,  12'd4,    16'd1,     1'b1, '{5'd29, 4'd2,  12'd4,    1'b0}},
      '{1'b0, 5'd31, 4'd1,  12'd2021, 16'd29,    1'b1, '{5'd1,  4'd3,  12'd2021, 1'b0}},
      '{1'b0, 5'd1,  4'd12, 12'd2000, 16'd31,    1'b1, '{5'd1,  4'd1,  12'd2001, 1'b0}},
      '{1'b1, 5'd31, 4'd12, 12'd4095, 16'd65535, 1'b0, NO_WANT},
      '{1'b0, 5'd1,  4'd1,  12'd1,    16'd65535, 1'b0, NO_WANT},
      '{1'b0, 5'd1,  4'd1,  12'd3950, 16'd65535, 1'b0, NO_WANT},
      '{1'b1, 5'd15, 4'd7,  12'd150,  16'd65535, 1'b0, NO_WANT},
      '{1'b1, 5'd31, 4'd1,  12'd4095, 16'd65535, 1'b0, NO_WANT}
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      sender_gap();
      offer_date(directed_rows[i]);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 1000) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_dates.size() != 0) @(negedge clk);
      end
      sender_gap();
      s = '0;
      s.kind = 1'($urandom);
      if ($urandom_range(99) < 15) begin
        s.d = 5'($urandom);
        s.m = 4'($urandom);
        s.y = 12'($urandom);
        s.offs = 16'($urandom);
      end else begin
        s.m = 4'($urandom_range(1, 12));
        pick = $urandom_range(99);
        // years near both ends so offsets run out of range
        if (pick < 20) s.y = 12'($urandom_range(1, 200));
        else if (pick < 40) s.y = 12'($urandom_range(3900, 4095));
        else s.y = 12'($urandom_range(1, 4095));
        s.d = 5'($urandom_range(1, month_days(s.m, s.y)));
        if ($urandom_range(99) < 30) s.offs = 16'($urandom_range(0, 400));
        else s.offs = 16'($urandom);
      end
      offer_date(s);
    end
    in_valid <= 1'b0;

    while (pending_dates.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dasd_pkg.sv
rtl/dasd_seq.sv
rtl/dasd_dp.sv
rtl/date_add_subtract_days.sv
tb/sv/date_add_subtract_days_tb.sv
